[sv/lsel_pkg.sv]
// Shared types, constants and helpers for the latent space edge likelihood block.
// Used by every module of the block; depends on nothing.
package lsel_pkg;

  // Default fraction bits of positions, radii, weights and totals.
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port.
  localparam logic REG_W_IN  = 1'b0;
  localparam logic REG_W_OUT = 1'b1;

  // ln(2) in Q.30 and the point at which exp(-x) underflows to zero.
  localparam logic [35:0] LN2_Q30  = 36'd744261118;
  localparam logic [35:0] EXP_CUT  = 36'd41 * LN2_Q30;
  localparam logic [30:0] QUOT_MAX = 31'h7FFF_FFFF;

  // Series lengths for exp and ln(1+x).
  localparam logic [3:0] TAYLOR_LAST = 4'd12;
  localparam logic [3:0] LOG_LAST    = 4'd15;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One classified pair as it waits for the back end.
  typedef struct packed {
    logic        self_pair;
    logic [30:0] dist_a;
    logic [30:0] dist_b;
    logic        scale;
    logic [30:0] rad_i;
    logic [30:0] rad_j;
    logic        edge_obs;
    logic [15:0] draw;
    logic        last;
  } lsel_job_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } lsel_div_req_t;

  // Answer of the shared divider.
  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } lsel_div_rsp_t;

  // Signed add that clamps at the 64-bit limits.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

endpackage

[sv/lsel_front.sv]
// Front end: takes pairs from the input channel and classifies them.
// Depends on lsel_pkg; feeds lsel_queue.
module lsel_front (
  input  logic                    push,
  output logic                    full,
  input  logic [9:0]              in_sender_node,
  input  logic [9:0]              in_receiver_node,
  input  logic signed [31:0]      in_sender_pos_x,
  input  logic signed [31:0]      in_sender_pos_y,
  input  logic signed [31:0]      in_receiver_pos_x,
  input  logic signed [31:0]      in_receiver_pos_y,
  input  logic [30:0]             in_sender_radius,
  input  logic [30:0]             in_receiver_radius,
  input  logic                    in_edge_observed,
  input  logic [15:0]             in_uniform_draw,
  input  logic                    in_last_pair,
  input  logic                    q_full,
  output logic                    q_push,
  output lsel_pkg::lsel_job_t     q_job
);
  import lsel_pkg::*;

  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic               big;

  // Exact coordinate differences and their magnitudes.
  assign dx = 33'(in_sender_pos_x) - 33'(in_receiver_pos_x);
  assign dy = 33'(in_sender_pos_y) - 33'(in_receiver_pos_y);
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);

  // Halve both offsets when either reaches 2^31 so the squares fit.
  assign big = ax[32] | ax[31] | ay[32] | ay[31];

  always_comb begin
    q_job.self_pair = (in_sender_node == in_receiver_node);
    q_job.dist_a    = big ? ax[31:1] : ax[30:0];
    q_job.dist_b    = big ? ay[31:1] : ay[30:0];
    q_job.scale     = big;
    q_job.rad_i     = in_sender_radius;
    q_job.rad_j     = in_receiver_radius;
    q_job.edge_obs  = in_edge_observed;
    q_job.draw      = in_uniform_draw;
    q_job.last      = in_last_pair;
  end

  // A word is taken whenever the queue has room.
  assign full   = q_full;
  assign q_push = push & ~q_full;

endmodule

[sv/lsel_queue.sv]
// Short queue of classified pairs between the front and back ends.
// Depends on lsel_pkg for the job type and depth.
module lsel_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  lsel_pkg::lsel_job_t  wr_data,
  output logic                 q_full,
  input  logic                 rd_en,
  output logic                 q_empty,
  output lsel_pkg::lsel_job_t  rd_data
);
  import lsel_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  lsel_job_t       mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_data = mem_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

[sv/lsel_div.sv]
// Shared unsigned long divider, two quotient bits per cycle.
// Depends on lsel_pkg; the dividend's upper half must be below the divisor.
module lsel_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsel_pkg::lsel_div_req_t req,
  output lsel_pkg::lsel_div_rsp_t rsp
);
  import lsel_pkg::*;

  logic [31:0] rem_r, rem_nxt, num_r, num_nxt, quot_r, quot_nxt, den_r, den_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] r1, r1s, r2, r2s;
  logic        ge1, ge2;

  // Two restoring steps per cycle.
  always_comb begin
    r1  = {rem_r, num_r[31]};
    ge1 = (r1 >= {1'b0, den_r});
    r1s = ge1 ? r1 - {1'b0, den_r} : r1;
    r2  = {r1s[31:0], num_r[30]};
    ge2 = (r2 >= {1'b0, den_r});
    r2s = ge2 ? r2 - {1'b0, den_r} : r2;
  end

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend[63:32];
      num_nxt  = req.dividend[31:0];
      den_nxt  = req.divisor;
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = r2s[31:0];
      num_nxt  = {num_r[29:0], 2'b00};
      quot_nxt = {quot_r[29:0], ge1, ge2};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

[sv/lsel_back.sv]
// Back end: sequencer that works one pair at a time through root, quotients,
// exp, sigmoid and log, then updates the running totals. Depends on lsel_pkg.
module lsel_back #(
  parameter int FRAC_BITS = lsel_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  lsel_pkg::lsel_job_t     q_job,
  output logic                    q_pop,
  input  logic signed [31:0]      w_in,
  input  logic signed [31:0]      w_out,
  output lsel_pkg::lsel_div_req_t div_req,
  input  lsel_pkg::lsel_div_rsp_t div_rsp,
  input  logic                    pop,
  output logic                    empty,
  output logic [16:0]             out_edge_probability,
  output logic                    out_sampled_edge,
  output logic signed [63:0]      out_likelihood_total,
  output logic signed [63:0]      out_grad_incoming_total,
  output logic signed [63:0]      out_grad_outgoing_total,
  output logic                    out_totals_final
);
  import lsel_pkg::*;

  localparam int          AXW     = 62 - FRAC_BITS;
  localparam logic [32:0] ONE_T   = 33'd1 << FRAC_BITS;
  localparam logic [32:0] LN_RND  = 33'd1 << (29 - FRAC_BITS);
  localparam logic [30:0] ONE30   = 31'h4000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_SQR, S_SQRT, S_QSET, S_QWAIT, S_ETAM, S_ETAS, S_EXPSET, S_ERED,
    S_TAYM, S_TAYW, S_EFIN, S_PDIV, S_PWAIT, S_SDIV, S_SWAIT, S_S2M,
    S_LOGD, S_LOGW, S_LOGM, S_FIN, S_ACC
  } state_t;

  state_t              state_r, state_nxt;
  lsel_job_t           job_r, job_nxt;
  logic [63:0]         sq_r, sq_nxt;
  logic [33:0]         rt_rem_r, rt_rem_nxt;
  logic [31:0]         root_r, root_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [32:0]         d_r, d_nxt;
  logic                qsel_r, qsel_nxt;
  logic signed [32:0]  t_i_r, t_i_nxt, t_j_r, t_j_nxt;
  logic signed [64:0]  pi_r, pi_nxt, po_r, po_nxt;
  logic signed [31:0]  eta_r, eta_nxt;
  logic [35:0]         red_r, red_nxt;
  logic [5:0]          nsh_r, nsh_nxt;
  logic [30:0]         term_r, term_nxt;
  logic signed [31:0]  esum_r, esum_nxt;
  logic [30:0]         e30_r, e30_nxt, p30_r, p30_nxt, s_r, s_nxt;
  logic [30:0]         s2_r, s2_nxt, pw_r, pw_nxt;
  logic [31:0]         lacc_r, lacc_nxt;
  logic signed [33:0]  ll_r, ll_nxt;
  logic [16:0]         prob_r, prob_nxt;
  logic signed [63:0]  acc_ll_r, acc_ll_nxt, acc_gi_r, acc_gi_nxt, acc_go_r, acc_go_nxt;
  logic                ov_r, ov_nxt;
  logic [16:0]         o_prob_r, o_prob_nxt;
  logic                o_samp_r, o_samp_nxt, o_fin_r, o_fin_nxt;
  logic signed [63:0]  o_ll_r, o_ll_nxt, o_gi_r, o_gi_nxt, o_go_r, o_go_nxt;

  // Working values of the current step.
  logic [35:0]         rem_sh, trial;
  logic [30:0]         r_sel, q_val;
  logic [63:0]         num64, lim64;
  logic signed [65:0]  eta_sum, eta_sh;
  logic [31:0]         mag;
  logic [AXW-1:0]      ax;
  logic [35:0]         lnk;
  logic [60:0]         tay_prod, sq_prod, pw_prod;
  logic signed [31:0]  esh;
  logic [32:0]         lnf;
  logic signed [31:0]  eta_part, res30;
  logic signed [63:0]  ll_add, gi_add, go_add, new_ll, new_gi, new_go;
  logic                out_free;

  assign out_free = ~ov_r | pop;

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    sq_nxt     = sq_r;
    rt_rem_nxt = rt_rem_r;
    root_nxt   = root_r;
    cnt_nxt    = cnt_r;
    d_nxt      = d_r;
    qsel_nxt   = qsel_r;
    t_i_nxt    = t_i_r;
    t_j_nxt    = t_j_r;
    pi_nxt     = pi_r;
    po_nxt     = po_r;
    eta_nxt    = eta_r;
    red_nxt    = red_r;
    nsh_nxt    = nsh_r;
    term_nxt   = term_r;
    esum_nxt   = esum_r;
    e30_nxt    = e30_r;
    p30_nxt    = p30_r;
    s_nxt      = s_r;
    s2_nxt     = s2_r;
    pw_nxt     = pw_r;
    lacc_nxt   = lacc_r;
    ll_nxt     = ll_r;
    prob_nxt   = prob_r;
    acc_ll_nxt = acc_ll_r;
    acc_gi_nxt = acc_gi_r;
    acc_go_nxt = acc_go_r;
    ov_nxt     = ov_r & ~pop;
    o_prob_nxt = o_prob_r;
    o_samp_nxt = o_samp_r;
    o_fin_nxt  = o_fin_r;
    o_ll_nxt   = o_ll_r;
    o_gi_nxt   = o_gi_r;
    o_go_nxt   = o_go_r;
    q_pop      = 1'b0;
    div_req    = '0;

    // Square root step.
    rem_sh = {rt_rem_r, sq_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};

    // Radius quotient setup.
    r_sel = qsel_r ? job_r.rad_j : job_r.rad_i;
    num64 = 64'(d_r) << FRAC_BITS;
    lim64 = 64'(r_sel) << 31;
    q_val = div_rsp.quot[30:0];

    // Eta from the two weighted terms.
    eta_sum = 66'(pi_r) + 66'(po_r);
    eta_sh  = eta_sum >>> FRAC_BITS;

    // Range reduction and series.
    mag      = eta_r[31] ? 32'(~eta_r) + 32'd1 : 32'(eta_r);
    ax       = AXW'(mag) << (30 - FRAC_BITS);
    lnk      = LN2_Q30 << cnt_r[2:0];
    tay_prod = 61'(term_r) * 61'(red_r[29:0]);
    sq_prod  = 61'(s_r) * 61'(s_r);
    pw_prod  = 61'(pw_r) * 61'(s2_r);
    esh      = esum_r >>> nsh_r;

    // Final terms.
    lnf      = ({lacc_r, 1'b0} + LN_RND) >> (30 - FRAC_BITS);
    eta_part = job_r.edge_obs ? (eta_r[31] ? eta_r : 32'sd0)
                              : ((!eta_r[31] && eta_r != 0) ? -eta_r : 32'sd0);
    res30    = (job_r.edge_obs ? 32'sh4000_0000 : 32'sd0) - $signed({1'b0, p30_r});

    // Totals.
    ll_add = 64'(ll_r);
    gi_add = 64'(pi_r >>> 30);
    go_add = 64'(po_r >>> 30);
    new_ll = sat_add64(acc_ll_r, ll_add);
    new_gi = sat_add64(acc_gi_r, gi_add);
    new_go = sat_add64(acc_go_r, go_add);

    case (state_r)
      // Take the next pair; a self pair goes straight to the totals.
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          if (q_job.self_pair) begin
            pi_nxt    = '0;
            po_nxt    = '0;
            ll_nxt    = '0;
            prob_nxt  = '0;
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_SQR;
          end
        end
      end
      // Sum of squares.
      S_SQR: begin
        sq_nxt     = 64'(62'(job_r.dist_a) * 62'(job_r.dist_a))
                   + 64'(62'(job_r.dist_b) * 62'(job_r.dist_b));
        rt_rem_nxt = '0;
        root_nxt   = '0;
        cnt_nxt    = '0;
        state_nxt  = S_SQRT;
      end
      // One root bit per cycle.
      S_SQRT: begin
        if (rem_sh >= trial) begin
          rt_rem_nxt = 34'(rem_sh - trial);
          root_nxt   = {root_r[30:0], 1'b1};
        end else begin
          rt_rem_nxt = rem_sh[33:0];
          root_nxt   = {root_r[30:0], 1'b0};
        end
        sq_nxt  = {sq_r[61:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          d_nxt     = job_r.scale ? {root_nxt, 1'b0} : {1'b0, root_nxt};
          qsel_nxt  = 1'b0;
          state_nxt = S_QSET;
        end
      end
      // Quotient d/r; a zero radius or a large quotient saturates.
      S_QSET: begin
        if (num64 >= lim64) begin
          if (qsel_r) begin
            t_j_nxt   = $signed(ONE_T - {2'b00, QUOT_MAX});
            state_nxt = S_ETAM;
          end else begin
            t_i_nxt   = $signed(ONE_T - {2'b00, QUOT_MAX});
            qsel_nxt  = 1'b1;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num64;
          div_req.divisor  = {1'b0, r_sel};
          state_nxt        = S_QWAIT;
        end
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          if (qsel_r) begin
            t_j_nxt   = $signed(ONE_T - {2'b00, q_val});
            state_nxt = S_ETAM;
          end else begin
            t_i_nxt   = $signed(ONE_T - {2'b00, q_val});
            qsel_nxt  = 1'b1;
            state_nxt = S_QSET;
          end
        end
      end
      // Weighted terms.
      S_ETAM: begin
        pi_nxt    = 65'(w_in) * 65'(t_j_r);
        po_nxt    = 65'(w_out) * 65'(t_i_r);
        state_nxt = S_ETAS;
      end
      S_ETAS: begin
        if (eta_sh > 66'sd2147483647) begin
          eta_nxt = 32'sh7FFF_FFFF;
        end else if (eta_sh < -66'sd2147483648) begin
          eta_nxt = 32'sh8000_0000;
        end else begin
          eta_nxt = eta_sh[31:0];
        end
        state_nxt = S_EXPSET;
      end
      // exp(-|eta|) underflows to zero past 41 halvings.
      S_EXPSET: begin
        nsh_nxt = '0;
        cnt_nxt = 5'd5;
        if (AXW'(EXP_CUT) <= ax) begin
          e30_nxt   = '0;
          state_nxt = S_PDIV;
        end else begin
          red_nxt   = ax[35:0];
          state_nxt = S_ERED;
        end
      end
      // Split off multiples of ln2, one quotient bit per cycle.
      S_ERED: begin
        if (red_r >= lnk) begin
          red_nxt               = red_r - lnk;
          nsh_nxt[cnt_r[2:0]]   = 1'b1;
        end
        if (cnt_r == '0) begin
          term_nxt  = ONE30;
          esum_nxt  = 32'sh4000_0000;
          cnt_nxt   = 5'd1;
          state_nxt = S_TAYM;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      // Taylor term: (term*r >> 30) / k.
      S_TAYM: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(tay_prod[60:30]);
        div_req.divisor  = 32'(cnt_r);
        state_nxt        = S_TAYW;
      end
      S_TAYW: begin
        if (div_rsp.done) begin
          term_nxt = q_val;
          esum_nxt = cnt_r[0] ? esum_r - $signed({1'b0, q_val})
                              : esum_r + $signed({1'b0, q_val});
          if (cnt_r[3:0] == TAYLOR_LAST) begin
            state_nxt = S_EFIN;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_TAYM;
          end
        end
      end
      S_EFIN: begin
        e30_nxt   = esh[30:0];
        state_nxt = S_PDIV;
      end
      // Sigmoid in Q.30.
      S_PDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = eta_r[31] ? (64'(e30_r) << 30) : (64'd1 << 60);
        div_req.divisor  = 32'(ONE30) + 32'(e30_r);
        state_nxt        = S_PWAIT;
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          p30_nxt   = q_val;
          state_nxt = S_SDIV;
        end
      end
      // s = e / (2 + e) for the log series.
      S_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(e30_r) << 30;
        div_req.divisor  = 32'h8000_0000 + 32'(e30_r);
        state_nxt        = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_rsp.done) begin
          s_nxt     = q_val;
          state_nxt = S_S2M;
        end
      end
      S_S2M: begin
        s2_nxt    = sq_prod[60:30];
        pw_nxt    = s_r;
        lacc_nxt  = '0;
        cnt_nxt   = 5'd1;
        state_nxt = S_LOGD;
      end
      // Odd powers of s over k, k = 1, 3, ... 15.
      S_LOGD: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(pw_r);
        div_req.divisor  = 32'(cnt_r);
        state_nxt        = S_LOGW;
      end
      S_LOGW: begin
        if (div_rsp.done) begin
          lacc_nxt = lacc_r + div_rsp.quot;
          if (cnt_r[3:0] == LOG_LAST) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_LOGM;
          end
        end
      end
      S_LOGM: begin
        pw_nxt    = pw_prod[60:30];
        cnt_nxt   = cnt_r + 5'd2;
        state_nxt = S_LOGD;
      end
      // Probability, likelihood term and gradient products.
      S_FIN: begin
        prob_nxt  = 17'((32'(p30_r) + 32'h2000) >> 14);
        ll_nxt    = 34'(eta_part) - $signed({1'b0, lnf});
        pi_nxt    = 65'(t_j_r) * 65'(res30);
        po_nxt    = 65'(t_i_r) * 65'(res30);
        state_nxt = S_ACC;
      end
      // Update totals and hand the word to the output register.
      S_ACC: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_prob_nxt = prob_r;
          o_samp_nxt = (17'(job_r.draw) < prob_r);
          o_fin_nxt  = job_r.last;
          o_ll_nxt   = new_ll;
          o_gi_nxt   = new_gi;
          o_go_nxt   = new_go;
          acc_ll_nxt = job_r.last ? '0 : new_ll;
          acc_gi_nxt = job_r.last ? '0 : new_gi;
          acc_go_nxt = job_r.last ? '0 : new_go;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, totals and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      acc_ll_r <= '0;
      acc_gi_r <= '0;
      acc_go_r <= '0;
      cnt_r    <= '0;
      qsel_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      acc_ll_r <= acc_ll_nxt;
      acc_gi_r <= acc_gi_nxt;
      acc_go_r <= acc_go_nxt;
      cnt_r    <= cnt_nxt;
      qsel_r   <= qsel_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    sq_r     <= sq_nxt;
    rt_rem_r <= rt_rem_nxt;
    root_r   <= root_nxt;
    d_r      <= d_nxt;
    t_i_r    <= t_i_nxt;
    t_j_r    <= t_j_nxt;
    pi_r     <= pi_nxt;
    po_r     <= po_nxt;
    eta_r    <= eta_nxt;
    red_r    <= red_nxt;
    nsh_r    <= nsh_nxt;
    term_r   <= term_nxt;
    esum_r   <= esum_nxt;
    e30_r    <= e30_nxt;
    p30_r    <= p30_nxt;
    s_r      <= s_nxt;
    s2_r     <= s2_nxt;
    pw_r     <= pw_nxt;
    lacc_r   <= lacc_nxt;
    ll_r     <= ll_nxt;
    prob_r   <= prob_nxt;
    o_prob_r <= o_prob_nxt;
    o_samp_r <= o_samp_nxt;
    o_fin_r  <= o_fin_nxt;
    o_ll_r   <= o_ll_nxt;
    o_gi_r   <= o_gi_nxt;
    o_go_r   <= o_go_nxt;
  end

  assign empty                   = ~ov_r;
  assign out_edge_probability    = o_prob_r;
  assign out_sampled_edge        = o_samp_r;
  assign out_likelihood_total    = o_ll_r;
  assign out_grad_incoming_total = o_gi_r;
  assign out_grad_outgoing_total = o_go_r;
  assign out_totals_final        = o_fin_r;

endmodule

[sv/latent_space_edge_likelihood_top.sv]
// Top level of the latent space edge likelihood block: configuration registers
// and the front, queue, shared divider and back end. Depends on lsel_pkg.
//
// Use: each input word is one ordered node pair (positions, radii, observed
// edge, uniform draw, last flag), written with push while full is low. Each
// word gives exactly one result word, read with pop while empty is low: the
// edge probability, the sampled edge and the three running totals, which
// clear after a word flagged as last.
// The back end works on one pair at a time: the square root, then 24 runs of
// the shared divider (two radius quotients, twelve exp terms, sigmoid, log
// argument, eight log terms). A saturated radius quotient skips its divider
// run. When exp(-|eta|) underflows the exp series is skipped. A self pair
// skips all of these and goes straight to the totals.
// The queue holds two pairs, so the sender can run ahead while one is worked.
// Reset clears the totals, sets both weights to one and empties the queue.
// A stalled receiver holds the result in the output register; the back end
// finishes the next pair and waits there before updating the totals.
// Weights are written over the APB port (index 0 at 0x0, index 1 at 0x4).
module latent_space_edge_likelihood_top #(
  parameter int FRAC_BITS = lsel_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               push,
  output logic               full,
  input  logic [9:0]         in_sender_node,
  input  logic [9:0]         in_receiver_node,
  input  logic signed [31:0] in_sender_pos_x,
  input  logic signed [31:0] in_sender_pos_y,
  input  logic signed [31:0] in_receiver_pos_x,
  input  logic signed [31:0] in_receiver_pos_y,
  input  logic [30:0]        in_sender_radius,
  input  logic [30:0]        in_receiver_radius,
  input  logic               in_edge_observed,
  input  logic [15:0]        in_uniform_draw,
  input  logic               in_last_pair,
  // Result channel.
  input  logic               pop,
  output logic               empty,
  output logic [16:0]        out_edge_probability,
  output logic               out_sampled_edge,
  output logic signed [63:0] out_likelihood_total,
  output logic signed [63:0] out_grad_incoming_total,
  output logic signed [63:0] out_grad_outgoing_total,
  output logic               out_totals_final
);
  import lsel_pkg::*;

  localparam logic [31:0] W_RESET = 32'd1 << FRAC_BITS;

  logic signed [31:0] w_in_r, w_in_nxt, w_out_r, w_out_nxt;
  logic               wr_hit;
  logic               q_full, q_push, q_empty, q_pop;
  lsel_job_t          f_job, q_job;
  lsel_div_req_t      div_req;
  lsel_div_rsp_t      div_rsp;

  // Weight registers.
  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_W_OUT) ? w_out_r : w_in_r;

  always_comb begin
    w_in_nxt  = w_in_r;
    w_out_nxt = w_out_r;
    if (wr_hit) begin
      if (paddr[2] == REG_W_IN) begin
        w_in_nxt = pwdata;
      end else begin
        w_out_nxt = pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_in_r  <= W_RESET;
      w_out_r <= W_RESET;
    end else begin
      w_in_r  <= w_in_nxt;
      w_out_r <= w_out_nxt;
    end
  end

  lsel_front u_front (
    .push               (push),
    .full               (full),
    .in_sender_node     (in_sender_node),
    .in_receiver_node   (in_receiver_node),
    .in_sender_pos_x    (in_sender_pos_x),
    .in_sender_pos_y    (in_sender_pos_y),
    .in_receiver_pos_x  (in_receiver_pos_x),
    .in_receiver_pos_y  (in_receiver_pos_y),
    .in_sender_radius   (in_sender_radius),
    .in_receiver_radius (in_receiver_radius),
    .in_edge_observed   (in_edge_observed),
    .in_uniform_draw    (in_uniform_draw),
    .in_last_pair       (in_last_pair),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (f_job)
  );

  lsel_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (f_job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_empty (q_empty),
    .rd_data (q_job)
  );

  lsel_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lsel_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .q_empty                 (q_empty),
    .q_job                   (q_job),
    .q_pop                   (q_pop),
    .w_in                    (w_in_r),
    .w_out                   (w_out_r),
    .div_req                 (div_req),
    .div_rsp                 (div_rsp),
    .pop                     (pop),
    .empty                   (empty),
    .out_edge_probability    (out_edge_probability),
    .out_sampled_edge        (out_sampled_edge),
    .out_likelihood_total    (out_likelihood_total),
    .out_grad_incoming_total (out_grad_incoming_total),
    .out_grad_outgoing_total (out_grad_outgoing_total),
    .out_totals_final        (out_totals_final)
  );

endmodule
